[rtl/cpualu_pkg.sv]
package cpualu_pkg;

  localparam int unsigned InWidth       = 45;
  localparam int unsigned InTdataWidth  = 48;
  localparam int unsigned OutWidth      = 21;
  localparam int unsigned OutTdataWidth = 24;

  typedef enum logic [5:0] {
    FN_ADD    = 6'd0,
    FN_ADC    = 6'd1,
    FN_SUB    = 6'd2,
    FN_SBC    = 6'd3,
    FN_AND    = 6'd4,
    FN_XOR    = 6'd5,
    FN_OR     = 6'd6,
    FN_CP     = 6'd7,
    FN_INC8   = 6'd8,
    FN_DEC8   = 6'd9,
    FN_RLC    = 6'd10,
    FN_RRC    = 6'd11,
    FN_RL     = 6'd12,
    FN_RR     = 6'd13,
    FN_SLA    = 6'd14,
    FN_SRA    = 6'd15,
    FN_SWAP   = 6'd16,
    FN_SRL    = 6'd17,
    FN_BIT    = 6'd18,
    FN_RES    = 6'd19,
    FN_SET    = 6'd20,
    FN_RLCA   = 6'd21,
    FN_RRCA   = 6'd22,
    FN_RLA    = 6'd23,
    FN_RRA    = 6'd24,
    FN_DAA    = 6'd25,
    FN_CPL    = 6'd26,
    FN_SCF    = 6'd27,
    FN_CCF    = 6'd28,
    FN_ADD16  = 6'd29,
    FN_ADDSPE = 6'd30,
    FN_INC16  = 6'd31,
    FN_DEC16  = 6'd32
  } func_e;

  // first member sits in the top bits
  typedef struct packed {
    logic        carry_in;
    logic        half_carry_in;
    logic        subtract_in;
    logic        zero_in;
    logic [2:0]  bit_index;
    logic [15:0] rhs_value;
    logic [15:0] lhs_value;
    logic [5:0]  func;
  } alu_in_t;

  typedef struct packed {
    logic        carry_out;
    logic        half_carry_out;
    logic        subtract_out;
    logic        zero_out;
    logic        write_result;
    logic [15:0] result;
  } alu_out_t;

endpackage

[rtl/cpu_alu_with_flags_top.sv]
// Flag-producing ALU of an 8-bit handheld-console processor on stream ports.
// Each beat carries one operation; the block returns one result beat for it
// once it has passed the input register and then the result register, and it
// takes a new beat on every clock while the output side keeps tready high. The
// single combinational pass between the two registers (an 8- or 16-bit add and
// a zero detect) sets the clock. Unused operation codes give a zero result, no
// write-back and all flags passed through.
module cpu_alu_with_flags_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // func, lhs_value, rhs_value, bit_index, zero_in, subtract_in,
  // half_carry_in, carry_in, zero pad
  input  logic [cpualu_pkg::InTdataWidth-1:0]    s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // result, write_result, zero_out, subtract_out, half_carry_out,
  // carry_out, zero pad
  output logic [cpualu_pkg::OutTdataWidth-1:0]   m_axis_tdata_o
);
  import cpualu_pkg::*;

  alu_in_t  in_q;
  logic     in_valid_q;
  alu_out_t out_q, out_d;
  logic     out_valid_q;
  logic     out_ready, in_ready;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign in_ready        = !in_valid_q || out_ready;
  assign s_axis_tready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_q <= alu_in_t'(s_axis_tdata_i[InWidth-1:0]);
    end
    if (out_ready && in_valid_q) begin
      out_q <= out_d;
    end
  end

  logic [7:0]  x, y;
  logic        ci, bin;
  logic [8:0]  sum9, diff9;
  logic [4:0]  hsum, hdiff;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_sum;
  logic [8:0]  sp_lo;
  logic [4:0]  sp_nib;
  logic        daa_hi, daa_lo, daa_c;
  logic [7:0]  daa_adj, daa_r;
  logic [7:0]  bit_mask;
  logic [15:0] res;
  logic        wr, zf, nf, hf, cf, zfr;

  assign x        = in_q.lhs_value[7:0];
  assign y        = in_q.rhs_value[7:0];
  assign ci       = (in_q.func == FN_ADC) && in_q.carry_in;
  assign bin      = (in_q.func == FN_SBC) && in_q.carry_in;
  assign sum9     = {1'b0, x} + {1'b0, y} + {8'd0, ci};
  assign hsum     = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, ci};
  assign diff9    = {1'b0, x} - {1'b0, y} - {8'd0, bin};
  assign hdiff    = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'd0, bin};
  assign sum17    = {1'b0, in_q.lhs_value} + {1'b0, in_q.rhs_value};
  assign sum13    = {1'b0, in_q.lhs_value[11:0]} + {1'b0, in_q.rhs_value[11:0]};
  assign sp_sum   = in_q.lhs_value + {{8{y[7]}}, y};
  assign sp_lo    = {1'b0, in_q.lhs_value[7:0]} + {1'b0, y};
  assign sp_nib   = {1'b0, in_q.lhs_value[3:0]} + {1'b0, y[3:0]};
  assign bit_mask = 8'd1 << in_q.bit_index;

  // decimal adjust
  always_comb begin
    daa_hi = in_q.carry_in || (x > 8'h99);
    daa_lo = in_q.half_carry_in || (x[3:0] > 4'h9);
    if (!in_q.subtract_in) begin
      daa_adj = (daa_hi ? 8'h60 : 8'h00) + (daa_lo ? 8'h06 : 8'h00);
      daa_r   = x + daa_adj;
      daa_c   = daa_hi;
    end else begin
      daa_adj = (in_q.half_carry_in ? 8'h06 : 8'h00) + (in_q.carry_in ? 8'h60 : 8'h00);
      daa_r   = x - daa_adj;
      daa_c   = in_q.carry_in;
    end
  end

  always_comb begin
    res = 16'd0;
    wr  = 1'b1;
    zf  = in_q.zero_in;
    nf  = in_q.subtract_in;
    hf  = in_q.half_carry_in;
    cf  = in_q.carry_in;
    zfr = 1'b0;
    unique case (in_q.func)
      FN_ADD, FN_ADC: begin
        res = {8'd0, sum9[7:0]}; nf = 1'b0; hf = hsum[4]; cf = sum9[8]; zfr = 1'b1;
      end
      FN_SUB, FN_SBC: begin
        res = {8'd0, diff9[7:0]}; nf = 1'b1; hf = hdiff[4]; cf = diff9[8]; zfr = 1'b1;
      end
      FN_CP: begin
        wr = 1'b0; nf = 1'b1; hf = hdiff[4]; cf = diff9[8]; zf = (diff9[7:0] == 8'd0);
      end
      FN_AND: begin
        res = {8'd0, x & y}; nf = 1'b0; hf = 1'b1; cf = 1'b0; zfr = 1'b1;
      end
      FN_XOR: begin
        res = {8'd0, x ^ y}; nf = 1'b0; hf = 1'b0; cf = 1'b0; zfr = 1'b1;
      end
      FN_OR: begin
        res = {8'd0, x | y}; nf = 1'b0; hf = 1'b0; cf = 1'b0; zfr = 1'b1;
      end
      FN_INC8: begin
        res = {8'd0, x + 8'd1}; nf = 1'b0; hf = (x[3:0] == 4'hF); zfr = 1'b1;
      end
      FN_DEC8: begin
        res = {8'd0, x - 8'd1}; nf = 1'b1; hf = (x[3:0] == 4'h0); zfr = 1'b1;
      end
      FN_RLC: begin
        res = {8'd0, x[6:0], x[7]}; cf = x[7]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_RRC: begin
        res = {8'd0, x[0], x[7:1]}; cf = x[0]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_RL: begin
        res = {8'd0, x[6:0], in_q.carry_in}; cf = x[7]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_RR: begin
        res = {8'd0, in_q.carry_in, x[7:1]}; cf = x[0]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_SLA: begin
        res = {8'd0, x[6:0], 1'b0}; cf = x[7]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_SRA: begin
        res = {8'd0, x[7], x[7:1]}; cf = x[0]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_SWAP: begin
        res = {8'd0, x[3:0], x[7:4]}; nf = 1'b0; hf = 1'b0; cf = 1'b0; zfr = 1'b1;
      end
      FN_SRL: begin
        res = {8'd0, 1'b0, x[7:1]}; cf = x[0]; nf = 1'b0; hf = 1'b0; zfr = 1'b1;
      end
      FN_BIT: begin
        wr = 1'b0; zf = !(|(x & bit_mask)); nf = 1'b0; hf = 1'b1;
      end
      FN_RES: res = {8'd0, x & ~bit_mask};
      FN_SET: res = {8'd0, x | bit_mask};
      FN_RLCA: begin
        res = {8'd0, x[6:0], x[7]}; cf = x[7]; nf = 1'b0; hf = 1'b0; zf = 1'b0;
      end
      FN_RRCA: begin
        res = {8'd0, x[0], x[7:1]}; cf = x[0]; nf = 1'b0; hf = 1'b0; zf = 1'b0;
      end
      FN_RLA: begin
        res = {8'd0, x[6:0], in_q.carry_in}; cf = x[7]; nf = 1'b0; hf = 1'b0; zf = 1'b0;
      end
      FN_RRA: begin
        res = {8'd0, in_q.carry_in, x[7:1]}; cf = x[0]; nf = 1'b0; hf = 1'b0; zf = 1'b0;
      end
      FN_DAA: begin
        res = {8'd0, daa_r}; cf = daa_c; hf = 1'b0; zfr = 1'b1;
      end
      FN_CPL: begin
        res = {8'd0, ~x}; nf = 1'b1; hf = 1'b1;
      end
      FN_SCF: begin
        wr = 1'b0; nf = 1'b0; hf = 1'b0; cf = 1'b1;
      end
      FN_CCF: begin
        wr = 1'b0; nf = 1'b0; hf = 1'b0; cf = !in_q.carry_in;
      end
      FN_ADD16: begin
        res = sum17[15:0]; nf = 1'b0; hf = sum13[12]; cf = sum17[16];
      end
      FN_ADDSPE: begin
        res = sp_sum; zf = 1'b0; nf = 1'b0; hf = sp_nib[4]; cf = sp_lo[8];
      end
      FN_INC16: res = in_q.lhs_value + 16'd1;
      FN_DEC16: res = in_q.lhs_value - 16'd1;
      default: wr = 1'b0;
    endcase
    if (zfr) begin
      zf = (res == 16'd0);
    end
  end

  always_comb begin
    out_d.result         = res;
    out_d.write_result   = wr;
    out_d.zero_out       = zf;
    out_d.subtract_out   = nf;
    out_d.half_carry_out = hf;
    out_d.carry_out      = cf;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataWidth - OutWidth){1'b0}}, out_q};

endmodule

[rtl/cpualu_checker.sv]
module cpualu_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_o,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [cpualu_pkg::OutTdataWidth-1:0] m_axis_tdata_o
);
  import cpualu_pkg::*;

  // no result beat while in reset
  a_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result beat offered during reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

  // an accepted beat must produce a result beat at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##1 m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  // no write-back means a zero result field
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[16] |-> m_axis_tdata_o[15:0] == 16'd0)
    else $error("result without write-back is not zero");

  // pad bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutTdataWidth-1:OutWidth] == '0)
    else $error("pad bits set in result beat");

endmodule

bind cpu_alu_with_flags_top cpualu_checker u_cpualu_checker (.*);
